/* rtl/flrp_pkg.sv */
package flrp_pkg;

	localparam int unsigned MAX_ID_BYTES_DEF   = 64;
	localparam int unsigned MAX_NAME_BYTES_DEF = 1024;
	localparam logic [15:0] MAX_FILES_RESET    = 16'd1024;

	localparam logic [7:0] CH_DOT       = 8'h2e;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_DEL       = 8'h7f;
	localparam logic [7:0] CH_SLASH     = 8'h2f;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_COLON     = 8'h3a;

	typedef enum logic [3:0] {
		PH_MAGIC    = 4'd0,
		PH_IDLEN    = 4'd1,
		PH_IDBYTE   = 4'd2,
		PH_COUNT    = 4'd3,
		PH_NAMELEN  = 4'd4,
		PH_NAMEBYTE = 4'd5,
		PH_SIZE     = 4'd6,
		PH_MOD      = 4'd7,
		PH_DONE     = 4'd8
	} phase_t;

	typedef enum logic [3:0] {
		FK_MAGIC    = 4'd0,
		FK_IDLEN    = 4'd1,
		FK_IDBYTE   = 4'd2,
		FK_COUNT    = 4'd3,
		FK_NAMELEN  = 4'd4,
		FK_NAMEBYTE = 4'd5,
		FK_SIZE     = 4'd6,
		FK_MOD      = 4'd7,
		FK_IGNORED  = 4'd8
	} field_kind_t;

	typedef enum logic [1:0] {
		VD_BUSY   = 2'd0,
		VD_ACCEPT = 2'd1,
		VD_REJECT = 2'd2
	} verdict_t;

	typedef enum logic [3:0] {
		ERR_NONE     = 4'd0,
		ERR_MAGIC    = 4'd1,
		ERR_IDLEN    = 4'd2,
		ERR_COUNT    = 4'd3,
		ERR_NAMELEN  = 4'd4,
		ERR_NAMECHAR = 4'd5,
		ERR_DOT      = 4'd6,
		ERR_TRUNC    = 4'd7,
		ERR_TRAIL    = 4'd8
	} err_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  byte_echo;
		field_kind_t field_kind;
		logic [15:0] file_number;
		logic [63:0] field_value;
		logic        field_done;
		verdict_t    verdict;
		err_kind_t   error_kind;
	} out_item_t;

	// "LDF1"
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		unique case (idx)
			2'd0: m = 8'h4c;
			2'd1: m = 8'h44;
			2'd2: m = 8'h46;
			2'd3: m = 8'h31;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	function automatic logic bad_name_char(input logic [7:0] c);
		return (c < CH_SPACE) || (c == CH_DEL) || (c == CH_SLASH)
			|| (c == CH_BACKSLASH) || (c == CH_COLON);
	endfunction

endpackage

/* rtl/file_list_record_parser.sv */
// Result path: an accepted byte request is held in the input register, then the
// parse logic writes its result into the result register, which offers it.
// Throughput: one byte per cycle; the phase machine and counters update once
// per byte, so only a stalled result side slows intake.
// Reset: parse state returns to the magic phase with no error; max_files = 1024.
module file_list_record_parser import flrp_pkg::*; #(
	parameter int unsigned MAX_ID_BYTES   = MAX_ID_BYTES_DEF,
	parameter int unsigned MAX_NAME_BYTES = MAX_NAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  in_item_t    rx_data,
	output logic        tx_valid,
	input  logic        tx_ready,
	output out_item_t   tx_data,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      free;
	logic      advance;
	out_item_t res;

	assign advance = valid_s1 && free;

	flrp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_data  (rx_data),
		.take     (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	flrp_core #(
		.MAX_ID_BYTES   (MAX_ID_BYTES),
		.MAX_NAME_BYTES (MAX_NAME_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (advance),
		.item      (item_s1),
		.res       (res)
	);

	flrp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.free     (free),
		.tx_valid (tx_valid),
		.tx_ready (tx_ready),
		.tx_data  (tx_data)
	);

endmodule

/* rtl/flrp_in_stage.sv */
module flrp_in_stage import flrp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     rx_valid,
	output logic     rx_ready,
	input  in_item_t rx_data,
	input  logic     take,
	output logic     valid_s1,
	output in_item_t item_s1
);

	logic valid_q;

	assign rx_ready = !valid_q || take;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rx_ready) begin
			valid_q <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			item_s1 <= rx_data;
		end
	end

endmodule

/* rtl/flrp_core.sv */
module flrp_core import flrp_pkg::*; #(
	parameter int unsigned MAX_ID_BYTES   = MAX_ID_BYTES_DEF,
	parameter int unsigned MAX_NAME_BYTES = MAX_NAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        step,
	input  in_item_t    item,
	output out_item_t   res
);

	localparam int unsigned STR_MAX = (MAX_ID_BYTES > MAX_NAME_BYTES) ?
		MAX_ID_BYTES : MAX_NAME_BYTES;
	localparam int unsigned SW = $clog2(STR_MAX + 1);

	logic [15:0]   max_files_q;
	phase_t        phase_q, phase_d;
	logic [3:0]    bp_q, bp_d;
	logic [63:0]   acc_q, acc_d;
	logic [SW-1:0] str_q, str_d;
	logic [15:0]   files_q, files_d;
	logic [15:0]   entry_q, entry_d;
	logic [1:0]    dot_q, dot_d;
	err_kind_t     err_q, err_d;

	logic [7:0]    b;
	logic [3:0]    bp_inc;
	logic [31:0]   len_acc;
	logic [1:0]    rem;
	logic [55:0]   bound;
	logic [15:0]   limit;
	err_kind_t     len_err;
	logic [SW-1:0] str_nx;
	logic [15:0]   files_nx;
	logic [1:0]    dot_nx;
	logic          accepted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_files_q <= MAX_FILES_RESET;
		end else if (cfg_we) begin
			max_files_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			bp_q    <= '0;
			acc_q   <= '0;
			str_q   <= '0;
			files_q <= '0;
			entry_q <= '0;
			dot_q   <= '0;
			err_q   <= ERR_NONE;
		end else if (step) begin
			phase_q <= phase_d;
			bp_q    <= bp_d;
			acc_q   <= acc_d;
			str_q   <= str_d;
			files_q <= files_d;
			entry_q <= entry_d;
			dot_q   <= dot_d;
			err_q   <= err_d;
		end
	end

	always_comb begin
		b        = item.data_byte;
		bp_inc   = bp_q + 4'd1;
		len_acc  = {acc_q[23:0], b};
		rem      = 2'(3'd4 - bp_inc[2:0]);
		bound    = {24'b0, len_acc} << {rem, 3'b000};
		str_nx   = (str_q != '0) ? str_q - SW'(1) : str_q;
		files_nx = (files_q != '0) ? files_q - 16'd1 : files_q;
		dot_nx   = (b == CH_DOT && dot_q < 2'd2) ? dot_q + 2'd1 : 2'd3;
		accepted = 1'b0;

		priority if (phase_q == PH_IDLEN) begin
			limit   = 16'(MAX_ID_BYTES);
			len_err = ERR_IDLEN;
		end else if (phase_q == PH_COUNT) begin
			limit   = max_files_q;
			len_err = ERR_COUNT;
		end else begin
			limit   = 16'(MAX_NAME_BYTES);
			len_err = ERR_NAMELEN;
		end

		phase_d = phase_q;
		bp_d    = bp_q;
		acc_d   = acc_q;
		str_d   = str_q;
		files_d = files_q;
		entry_d = entry_q;
		dot_d   = dot_q;
		err_d   = err_q;

		res.byte_echo   = b;
		res.field_kind  = FK_IGNORED;
		res.file_number = '0;
		res.field_value = '0;
		res.field_done  = 1'b0;

		if (err_q == ERR_NONE) begin
			unique case (phase_q)
				PH_MAGIC: begin
					res.field_kind = FK_MAGIC;
					if (b != magic_byte(bp_q[1:0])) begin
						err_d = ERR_MAGIC;
					end else if (bp_inc >= 4'd4) begin
						phase_d = PH_IDLEN;
						bp_d    = '0;
						acc_d   = '0;
					end else begin
						bp_d = bp_inc;
					end
				end
				PH_IDLEN, PH_COUNT, PH_NAMELEN: begin
					res.field_kind  = (phase_q == PH_IDLEN) ? FK_IDLEN :
						(phase_q == PH_COUNT) ? FK_COUNT : FK_NAMELEN;
					res.file_number = (phase_q == PH_NAMELEN) ? entry_q : 16'd0;
					res.field_value = {32'b0, len_acc};
					res.field_done  = (rem == 2'd0);
					acc_d = {32'b0, len_acc};
					bp_d  = bp_inc;
					// reject as soon as the prefix forces the value past its limit
					if ((|bound[55:16]) || (bound[15:0] > limit)) begin
						err_d = len_err;
					end else if (rem == 2'd0) begin
						if (len_acc == 32'd0) begin
							err_d = len_err;
						end else if (phase_q == PH_IDLEN) begin
							str_d   = len_acc[SW-1:0];
							phase_d = PH_IDBYTE;
						end else if (phase_q == PH_COUNT) begin
							files_d = len_acc[15:0];
							entry_d = '0;
							phase_d = PH_NAMELEN;
							bp_d    = '0;
							acc_d   = '0;
						end else begin
							str_d   = len_acc[SW-1:0];
							dot_d   = '0;
							phase_d = PH_NAMEBYTE;
						end
					end
				end
				PH_IDBYTE: begin
					res.field_kind = FK_IDBYTE;
					str_d = str_nx;
					if (str_nx == '0) begin
						phase_d = PH_COUNT;
						bp_d    = '0;
						acc_d   = '0;
					end
				end
				PH_NAMEBYTE: begin
					res.field_kind  = FK_NAMEBYTE;
					res.file_number = entry_q;
					if (bad_name_char(b)) begin
						err_d = ERR_NAMECHAR;
					end else begin
						dot_d = dot_nx;
						str_d = str_nx;
						if (str_nx == '0) begin
							if (dot_nx == 2'd1 || dot_nx == 2'd2) begin
								err_d = ERR_DOT;
							end else begin
								phase_d = PH_SIZE;
								bp_d    = '0;
								acc_d   = '0;
							end
						end
					end
				end
				PH_SIZE, PH_MOD: begin
					res.field_kind  = (phase_q == PH_SIZE) ? FK_SIZE : FK_MOD;
					res.file_number = entry_q;
					res.field_value = {acc_q[55:0], b};
					acc_d = {acc_q[55:0], b};
					bp_d  = bp_inc;
					if (bp_inc >= 4'd8) begin
						res.field_done = 1'b1;
						if (phase_q == PH_SIZE) begin
							phase_d = PH_MOD;
							bp_d    = '0;
							acc_d   = '0;
						end else begin
							entry_d = entry_q + 16'd1;
							files_d = files_nx;
							if (files_nx == 16'd0) begin
								phase_d = PH_DONE;
							end else begin
								phase_d = PH_NAMELEN;
								bp_d    = '0;
								acc_d   = '0;
							end
						end
					end
				end
				default: begin
					err_d = ERR_TRAIL;
				end
			endcase

			if (err_d == ERR_NONE && item.last) begin
				if (phase_d == PH_DONE) begin
					accepted = 1'b1;
				end else begin
					err_d = ERR_TRUNC;
				end
			end
		end

		res.error_kind = err_d;
		res.verdict    = (err_d != ERR_NONE) ? VD_REJECT :
			(accepted ? VD_ACCEPT : VD_BUSY);

		// end of message: back to the start
		if (item.last) begin
			phase_d = PH_MAGIC;
			bp_d    = '0;
			acc_d   = '0;
			str_d   = '0;
			files_d = '0;
			entry_d = '0;
			dot_d   = '0;
			err_d   = ERR_NONE;
		end
	end

endmodule

/* rtl/flrp_out_stage.sv */
module flrp_out_stage import flrp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_item_t res,
	output logic      free,
	output logic      tx_valid,
	input  logic      tx_ready,
	output out_item_t tx_data
);

	logic valid_q;

	assign free     = !valid_q || tx_ready;
	assign tx_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (tx_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tx_data <= res;
		end
	end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import flrp_pkg::*;

	localparam int RESULT_LATENCY = 2;
	localparam int STALL_LIMIT    = 2000;
	localparam int PRINT_LIMIT    = 100;
	localparam logic [31:0] MAGIC_WORD = 32'h4c444631;

	typedef enum int {
		FL_NONE,
		FL_NO_LAST,
		FL_TRUNCATE,
		FL_TRAILING,
		FL_BAD_MAGIC,
		FL_BAD_IDLEN,
		FL_BAD_COUNT,
		FL_BAD_NAMELEN,
		FL_BAD_CHAR,
		FL_DOT_NAME,
		FL_NOISE
	} flaw_t;

	typedef enum int {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_EVERY4,
		RDY_LONG
	} ready_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        rx_valid;
	logic        rx_ready;
	in_item_t    rx_data;
	logic        tx_valid;
	logic        tx_ready = 1'b0;
	out_item_t   tx_data;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	// parser state mirror
	phase_t      ph;
	logic [3:0]  pos;
	logic [63:0] acc;
	logic [10:0] str_left;
	logic [15:0] files_left;
	logic [15:0] entry;
	logic [1:0]  dots;
	err_kind_t   err_q;
	logic [15:0] max_cfg;

	out_item_t   expected_q[$];
	out_item_t   want;
	logic [7:0]  msg_bytes[$];
	int          mismatches = 0;
	int          bytes_sent = 0;
	int          burst_left = 0;

	ready_mode_t rdy_mode = RDY_ALWAYS;
	int          mode_left = 0;
	int          hold_left = 0;
	int          beat = 0;

	file_list_record_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_data  (rx_data),
		.tx_valid (tx_valid),
		.tx_ready (tx_ready),
		.tx_data  (tx_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic name_byte_banned(input logic [7:0] c);
		return (c < CH_SPACE) || (c == CH_DEL) || (c == CH_SLASH)
			|| (c == CH_BACKSLASH) || (c == CH_COLON);
	endfunction

	function automatic void clear_parse();
		ph = PH_MAGIC;
		pos = '0;
		acc = '0;
		str_left = '0;
		files_left = '0;
		entry = '0;
		dots = '0;
		err_q = ERR_NONE;
	endfunction

	function automatic void restart_int(input phase_t nxt);
		ph = nxt;
		pos = '0;
		acc = '0;
	endfunction

	function automatic out_item_t parse_predict(input logic [7:0] b, input logic lst);
		out_item_t   r;
		logic [63:0] bound;
		logic [63:0] limit;
		int          rem;
		err_kind_t   e;
		logic        accepted;
		r = '0;
		r.byte_echo = b;
		r.field_kind = FK_IGNORED;
		accepted = 1'b0;
		if (err_q == ERR_NONE) begin
			case (ph)
				PH_MAGIC: begin
					r.field_kind = FK_MAGIC;
					if (b != MAGIC_WORD[(31 - 8 * pos[1:0]) -: 8]) begin
						err_q = ERR_MAGIC;
					end else begin
						pos = pos + 4'd1;
						if (pos >= 4) restart_int(PH_IDLEN);
					end
				end
				PH_IDLEN, PH_COUNT, PH_NAMELEN: begin
					r.field_kind = field_kind_t'(ph);
					if (ph == PH_NAMELEN) r.file_number = entry;
					acc = {32'd0, acc[23:0], b};
					pos = (pos + 4'd1) & 4'd7;
					r.field_value = acc;
					rem = (pos < 4) ? 4 - pos : 0;
					if (rem == 0) r.field_done = 1'b1;
					if (ph == PH_IDLEN) begin
						limit = 64'(MAX_ID_BYTES_DEF);
						e = ERR_IDLEN;
					end else if (ph == PH_COUNT) begin
						limit = {48'd0, max_cfg};
						e = ERR_COUNT;
					end else begin
						limit = 64'(MAX_NAME_BYTES_DEF);
						e = ERR_NAMELEN;
					end
					// reject as soon as the prefix alone exceeds the limit
					bound = acc << (8 * rem);
					if (bound > limit) begin
						err_q = e;
					end else if (rem == 0) begin
						if (acc == 0) begin
							err_q = e;
						end else if (ph == PH_IDLEN) begin
							str_left = acc[10:0];
							ph = PH_IDBYTE;
						end else if (ph == PH_COUNT) begin
							files_left = acc[15:0];
							entry = '0;
							restart_int(PH_NAMELEN);
						end else begin
							str_left = acc[10:0];
							dots = '0;
							ph = PH_NAMEBYTE;
						end
					end
				end
				PH_IDBYTE: begin
					r.field_kind = FK_IDBYTE;
					if (str_left > 0) str_left = str_left - 11'd1;
					if (str_left == 0) restart_int(PH_COUNT);
				end
				PH_NAMEBYTE: begin
					r.field_kind = FK_NAMEBYTE;
					r.file_number = entry;
					if (name_byte_banned(b)) begin
						err_q = ERR_NAMECHAR;
					end else begin
						// saturate at 3 once anything but a dot, or a third dot, shows up
						if (b == CH_DOT && dots < 2) dots = dots + 2'd1;
						else dots = 2'd3;
						if (str_left > 0) str_left = str_left - 11'd1;
						if (str_left == 0) begin
							if (dots == 2'd1 || dots == 2'd2) err_q = ERR_DOT;
							else restart_int(PH_SIZE);
						end
					end
				end
				PH_SIZE, PH_MOD: begin
					r.field_kind = field_kind_t'(ph);
					r.file_number = entry;
					acc = {acc[55:0], b};
					pos = (pos + 4'd1) & 4'd15;
					r.field_value = acc;
					if (pos >= 8) begin
						r.field_done = 1'b1;
						if (ph == PH_SIZE) begin
							restart_int(PH_MOD);
						end else begin
							entry = entry + 16'd1;
							if (files_left > 0) files_left = files_left - 16'd1;
							if (files_left == 0) ph = PH_DONE;
							else restart_int(PH_NAMELEN);
						end
					end
				end
				default: begin
					r.field_kind = FK_IGNORED;
					err_q = ERR_TRAIL;
				end
			endcase
			if (err_q == ERR_NONE && lst) begin
				if (ph == PH_DONE) accepted = 1'b1;
				else err_q = ERR_TRUNC;
			end
		end
		r.verdict = (err_q != ERR_NONE) ? VD_REJECT : (accepted ? VD_ACCEPT : VD_BUSY);
		r.error_kind = err_q;
		if (lst) clear_parse();
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		if (mismatches < PRINT_LIMIT)
			$display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got,
				exp_val);
		mismatches++;
	endtask

	task automatic check_result(input out_item_t got, input out_item_t exp_item);
		if (got.byte_echo !== exp_item.byte_echo)
			report_mismatch("byte_echo", 64'(got.byte_echo), 64'(exp_item.byte_echo));
		if (got.field_kind !== exp_item.field_kind)
			report_mismatch("field_kind", 64'(got.field_kind), 64'(exp_item.field_kind));
		if (got.file_number !== exp_item.file_number)
			report_mismatch("file_number", 64'(got.file_number),
				64'(exp_item.file_number));
		if (got.field_value !== exp_item.field_value)
			report_mismatch("field_value", got.field_value, exp_item.field_value);
		if (got.field_done !== exp_item.field_done)
			report_mismatch("field_done", 64'(got.field_done), 64'(exp_item.field_done));
		if (got.verdict !== exp_item.verdict)
			report_mismatch("verdict", 64'(got.verdict), 64'(exp_item.verdict));
		if (got.error_kind !== exp_item.error_kind)
			report_mismatch("error_kind", 64'(got.error_kind), 64'(exp_item.error_kind));
	endtask

	// check results first, then queue the prediction for the request taken here
	always @(posedge clk) begin
		if (arst_n) begin
			if (tx_valid && tx_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with nothing pending", 64'(tx_data.byte_echo),
						'0);
				end else begin
					want = expected_q.pop_front();
					check_result(tx_data, want);
				end
			end
			if (rx_valid && rx_ready)
				expected_q.push_back(parse_predict(rx_data.data_byte, rx_data.last));
		end
	end

	// result-side back-pressure, switching pattern at random intervals
	always @(negedge clk) begin
		if (mode_left == 0) begin
			rdy_mode = ready_mode_t'($urandom_range(RDY_ALWAYS, RDY_LONG));
			mode_left = $urandom_range(50, 400);
		end else begin
			mode_left--;
		end
		case (rdy_mode)
			RDY_ALWAYS: tx_ready <= 1'b1;
			RDY_COIN: tx_ready <= 1'($urandom_range(0, 1));
			RDY_EVERY4: tx_ready <= (beat % 4 != 3);
			default: begin
				if (hold_left > 0) begin
					hold_left--;
					tx_ready <= 1'b0;
				end else if ($urandom_range(0, 15) == 0) begin
					hold_left = $urandom_range(1, 40);
					tx_ready <= 1'b0;
				end else begin
					tx_ready <= 1'b1;
				end
			end
		endcase
		beat++;
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (rx_valid && rx_ready) || (tx_valid && tx_ready)) quiet = 0;
			else quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if ($urandom_range(0, 31) == 0) gap = $urandom_range(10, 20);
			if (gap > 0) begin
				@(negedge clk);
				rx_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		@(negedge clk);
		rx_valid <= 1'b1;
		rx_data <= '{data_byte: b, last: l};
		do @(posedge clk); while (!rx_ready);
		bytes_sent++;
	endtask

	task automatic wait_parser_idle();
		@(negedge clk);
		rx_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (RESULT_LATENCY + 2) @(posedge clk);
	endtask

	task automatic set_max_files(input logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		max_cfg = v;
	endtask

	task automatic push_be(input logic [63:0] v, input int n);
		int k;
		for (k = n - 1; k >= 0; k--) msg_bytes.push_back(v[8 * k +: 8]);
	endtask

	task automatic ship_message(input logic with_last);
		int i;
		for (i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], with_last && (i == msg_bytes.size() - 1));
	endtask

	function automatic logic [7:0] legal_name_byte();
		logic [7:0] c;
		if ($urandom_range(0, 7) == 0) return CH_DOT;
		do c = 8'($urandom_range(0, 255)); while (name_byte_banned(c));
		return c;
	endfunction

	function automatic logic [7:0] banned_byte();
		logic [7:0] c;
		case ($urandom_range(0, 4))
			0: c = 8'($urandom_range(0, 31));
			1: c = CH_DEL;
			2: c = CH_SLASH;
			3: c = CH_BACKSLASH;
			default: c = CH_COLON;
		endcase
		return c;
	endfunction

	function automatic logic [63:0] pick_u64();
		logic [63:0] v;
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = '1;
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	task automatic build_message(input flaw_t flaw, input int force_id, input int force_name);
		int          id_len;
		int          nfiles;
		int          cap;
		int          bad_file;
		int          name_len;
		int          i;
		int          j;
		logic [31:0] v;
		msg_bytes.delete();
		if (flaw == FL_NOISE) begin
			// now and then lead with one byte of the magic word so noise can get past the first byte
			if ($urandom_range(0, 1))
				push_be(64'(MAGIC_WORD >> (8 * $urandom_range(0, 3))), 1);
			repeat ($urandom_range(1, 10)) msg_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		push_be(64'(MAGIC_WORD), 4);
		if (flaw == FL_BAD_MAGIC) begin
			i = $urandom_range(0, 3);
			msg_bytes[i] = msg_bytes[i] ^ 8'($urandom_range(1, 255));
		end

		if (force_id != 0) id_len = force_id;
		else if ($urandom_range(0, 7) == 0) id_len = $urandom_range(1, MAX_ID_BYTES_DEF);
		else id_len = $urandom_range(1, 6);
		v = id_len;
		if (flaw == FL_BAD_IDLEN) begin
			case ($urandom_range(0, 2))
				0: v = 0;
				1: v = $urandom_range(MAX_ID_BYTES_DEF + 1, 300);
				default: v = $urandom | 32'h0100_0000;
			endcase
		end
		push_be(64'(v), 4);
		repeat (id_len) msg_bytes.push_back(8'($urandom_range(0, 255)));

		cap = (max_cfg < 3) ? max_cfg : 3;
		nfiles = (cap == 0 || force_name != 0) ? 1 : $urandom_range(1, cap);
		v = nfiles;
		// sometimes a count at or above the files sent; a count above it ends the message early
		if (force_name == 0 && $urandom_range(0, 9) == 0 && max_cfg > nfiles)
			v = $urandom_range(nfiles, max_cfg);
		if (flaw == FL_BAD_COUNT)
			v = $urandom_range(0, 1) ? 0 : max_cfg + $urandom_range(1, 70000);
		push_be(64'(v), 4);

		bad_file = $urandom_range(0, nfiles - 1);
		for (i = 0; i < nfiles; i++) begin
			if (force_name != 0) name_len = force_name;
			else if ($urandom_range(0, 79) == 0) name_len = $urandom_range(13, 300);
			else name_len = $urandom_range(1, 12);
			if (i == bad_file && flaw == FL_DOT_NAME) name_len = $urandom_range(1, 2);
			v = name_len;
			if (i == bad_file && flaw == FL_BAD_NAMELEN) begin
				case ($urandom_range(0, 2))
					0: v = 0;
					1: v = $urandom_range(MAX_NAME_BYTES_DEF + 1, 3000);
					default: v = $urandom | 32'h0001_0000;
				endcase
			end
			push_be(64'(v), 4);
			for (j = 0; j < name_len; j++) begin
				if (i == bad_file && flaw == FL_DOT_NAME) msg_bytes.push_back(CH_DOT);
				else msg_bytes.push_back(legal_name_byte());
			end
			if (i == bad_file && flaw == FL_BAD_CHAR)
				msg_bytes[msg_bytes.size() - 1 - $urandom_range(0, name_len - 1)] = banned_byte();
			push_be(pick_u64(), 8);
			push_be(pick_u64(), 8);
		end

		if (flaw == FL_TRUNCATE) begin
			j = $urandom_range(1, msg_bytes.size() - 1);
			while (msg_bytes.size() > j) void'(msg_bytes.pop_back());
		end
		if (flaw == FL_TRAILING)
			repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic test_bad_magic();
		// magic error on a last-marked byte wins over truncation
		send_byte(8'h4c, 1'b0);
		send_byte(8'h00, 1'b1);
		// short good prefix cut by last
		send_byte(8'h4c, 1'b0);
		send_byte(8'h44, 1'b0);
		send_byte(8'h46, 1'b1);
	endtask

	task automatic test_early_length();
		// id length prefix 00 01 already exceeds the limit; next byte is ignored
		msg_bytes.delete();
		push_be(64'(MAGIC_WORD), 4);
		push_be(64'h0001, 2);
		push_be(64'hff, 1);
		ship_message(1'b1);
	endtask

	task automatic test_minimal_message();
		msg_bytes.delete();
		push_be(64'(MAGIC_WORD), 4);
		push_be(64'd1, 4);
		push_be(64'h00, 1);
		push_be(64'd1, 4);
		push_be(64'd1, 4);
		push_be(64'hff, 1);
		push_be('1, 8);
		push_be('0, 8);
		ship_message(1'b1);
	endtask

	task automatic test_longest_fields();
		build_message(FL_NONE, MAX_ID_BYTES_DEF, MAX_NAME_BYTES_DEF);
		ship_message(1'b1);
	endtask

	task automatic test_random_messages(input int n_bytes);
		int    stop_at;
		flaw_t flaw;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 99) < 55) flaw = FL_NONE;
			else flaw = flaw_t'($urandom_range(FL_NO_LAST, FL_NOISE));
			build_message(flaw, 0, 0);
			ship_message(flaw != FL_NO_LAST);
		end
		wait_parser_idle();
	endtask

	task automatic test_file_limit_sweep();
		set_max_files(16'd1);
		test_random_messages(20);
		set_max_files(16'hffff);
		test_longest_fields();
		test_random_messages(30);
		set_max_files(16'd0);
		test_random_messages(20);
		set_max_files(16'($urandom_range(2, 20)));
		test_random_messages(20);
		set_max_files(MAX_FILES_RESET);
		test_random_messages(30);
	endtask

	initial begin
		arst_n = 1'b0;
		rx_valid = 1'b0;
		rx_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		clear_parse();
		max_cfg = MAX_FILES_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_bad_magic();
		test_early_length();
		test_minimal_message();
		test_random_messages(40);
		test_file_limit_sweep();
		wait_parser_idle();

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
